FILE: rtl/sfp_pkg.sv
package sfp_pkg;

    // Queue and floor geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int NUM_FLOORS  = 8;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Fixed field widths.
    localparam int FLOOR_W = 4;
    localparam int STEP_W  = 16;
    localparam int PHASE_W = 3;
    localparam int COIL_W  = 8;
    localparam int PEND_W  = 3;

    localparam logic [STEP_W-1:0]  STEPS_RESET = 16'd4096;
    localparam logic [QCNT_W-1:0]  QUEUE_FULL  = QCNT_W'(QUEUE_DEPTH);
    localparam logic [QPTR_W-1:0]  QPTR_LAST   = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FLOOR_W-1:0] FLOOR_LOW   = 4'd1;
    localparam logic [FLOOR_W-1:0] FLOOR_HIGH  = 4'd15;
    localparam logic [FLOOR_W-1:0] FLOOR_TOP   = FLOOR_W'(NUM_FLOORS);

    // Item kinds carried on the input tuser.
    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    // Coil value driven at every floor boundary.
    localparam logic [COIL_W-1:0] COIL_HOLD = 8'h07;

    typedef struct packed {
        logic [COIL_W-1:0]  coil_byte;
        logic               coil_write;
        logic [FLOOR_W-1:0] current_floor;
        logic               going_up;
        logic               moving;
        logic               arrived;
        logic [PEND_W-1:0]  pending_count;
        logic               request_rejected;
    } t_result;

    // Half-step pattern, inverted and moved up to the coil bits.
    function automatic logic [COIL_W-1:0] coil_of(input logic [PHASE_W-1:0] idx);
        logic [COIL_W-1:0] pat;
        case (idx)
            3'd0:    pat = 8'h07;
            3'd1:    pat = 8'h03;
            3'd2:    pat = 8'h0b;
            3'd3:    pat = 8'h09;
            3'd4:    pat = 8'h0d;
            3'd5:    pat = 8'h0c;
            3'd6:    pat = 8'h0e;
            default: pat = 8'h06;
        endcase
        return {~pat[4:0], 3'b000};
    endfunction

endpackage

FILE: rtl/sfp_core.sv
module sfp_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic                          i_cmd,
    input  logic [sfp_pkg::FLOOR_W-1:0]   i_target,
    input  logic [sfp_pkg::STEP_W-1:0]    i_steps_per_floor,
    output sfp_pkg::t_result              o_result
);
    import sfp_pkg::*;

    logic [FLOOR_W-1:0] r_floor,  n_floor;
    logic               r_dir_up, n_dir_up;
    logic [PHASE_W-1:0] r_phase,  n_phase;
    logic [STEP_W-1:0]  r_steps,  n_steps;
    logic               r_busy,   n_busy;
    logic [QPTR_W-1:0]  r_head,   n_head;
    logic [QCNT_W-1:0]  r_count,  n_count;
    logic [FLOOR_W-1:0] r_store [QUEUE_DEPTH];

    logic [FLOOR_W-1:0] head_tgt;
    logic [STEP_W-1:0]  load_val;
    logic [STEP_W-1:0]  step_base;
    logic [QPTR_W:0]    tail_sum;
    logic [QPTR_W-1:0]  tail_idx;
    logic [QPTR_W-1:0]  head_next;
    logic               push;
    logic               do_step;
    logic               start;
    logic               rejected;
    logic               arrived;
    logic               coil_wr;
    logic [COIL_W-1:0]  coil;

    assign head_tgt  = r_store[r_head];
    assign load_val  = (i_steps_per_floor == '0) ? STEP_W'(1) : i_steps_per_floor;
    assign head_next = (r_head == QPTR_LAST) ? '0 : r_head + QPTR_W'(1);

    // Tail slot: head plus fill level, wrapped once.
    assign tail_sum = {1'b0, r_head} + (QPTR_W+1)'(r_count);
    assign tail_idx = (tail_sum >= (QPTR_W+1)'(QUEUE_DEPTH))
                    ? QPTR_W'(tail_sum - (QPTR_W+1)'(QUEUE_DEPTH))
                    : QPTR_W'(tail_sum);

    always_comb begin
        n_floor   = r_floor;
        n_dir_up  = r_dir_up;
        n_phase   = r_phase;
        n_steps   = r_steps;
        n_busy    = r_busy;
        n_head    = r_head;
        n_count   = r_count;
        push      = 1'b0;
        do_step   = 1'b0;
        start     = 1'b0;
        rejected  = 1'b0;
        arrived   = 1'b0;
        coil_wr   = 1'b0;
        coil      = '0;
        step_base = r_steps;

        if (i_fire) begin
            if (i_cmd == CMD_REQUEST) begin
                if (i_target == '0 || i_target > FLOOR_TOP || r_count >= QUEUE_FULL) begin
                    rejected = 1'b1;
                end else begin
                    push    = 1'b1;
                    n_count = r_count + QCNT_W'(1);
                end
            end else if (r_count != '0) begin
                if (!r_busy) begin
                    if (head_tgt == r_floor) begin
                        n_head  = head_next;
                        n_count = r_count - QCNT_W'(1);
                        arrived = 1'b1;
                    end else begin
                        n_dir_up = (head_tgt > r_floor);
                        n_busy   = 1'b1;
                        start    = 1'b1;
                        do_step  = 1'b1;
                    end
                end else if (r_steps != '0) begin
                    do_step = 1'b1;
                end else begin
                    // Floor boundary: hold the coils and move one floor.
                    coil    = COIL_HOLD;
                    coil_wr = 1'b1;
                    if (r_dir_up) begin
                        if (r_floor < FLOOR_HIGH) begin
                            n_floor = r_floor + FLOOR_W'(1);
                        end
                    end else begin
                        if (r_floor > FLOOR_LOW) begin
                            n_floor = r_floor - FLOOR_W'(1);
                        end
                    end
                    if (n_floor == head_tgt) begin
                        n_busy  = 1'b0;
                        n_head  = head_next;
                        n_count = r_count - QCNT_W'(1);
                        arrived = 1'b1;
                    end else begin
                        n_steps = load_val;
                    end
                end

                if (do_step) begin
                    step_base = start ? load_val : r_steps;
                    coil      = coil_of(r_phase);
                    coil_wr   = 1'b1;
                    n_phase   = n_dir_up ? r_phase + PHASE_W'(1) : r_phase - PHASE_W'(1);
                    n_steps   = step_base - STEP_W'(1);
                end
            end
        end
    end

    always_comb begin
        o_result.coil_byte        = coil;
        o_result.coil_write       = coil_wr;
        o_result.current_floor    = n_floor;
        o_result.going_up         = n_dir_up;
        o_result.moving           = n_busy;
        o_result.arrived          = arrived;
        o_result.pending_count    = PEND_W'(n_count);
        o_result.request_rejected = rejected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor  <= FLOOR_LOW;
            r_dir_up <= 1'b1;
            r_phase  <= '0;
            r_steps  <= '0;
            r_busy   <= 1'b0;
            r_head   <= '0;
            r_count  <= '0;
        end else begin
            r_floor  <= n_floor;
            r_dir_up <= n_dir_up;
            r_phase  <= n_phase;
            r_steps  <= n_steps;
            r_busy   <= n_busy;
            r_head   <= n_head;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_store[tail_idx] <= i_target;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_FULL)
        else $error("queue fill level above depth");

    a_busy_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_count != '0)
        else $error("motor running with an empty queue");

    a_arrive_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        arrived |=> r_count == $past(r_count) - QCNT_W'(1))
        else $error("arrival did not pop the head request");

endmodule

FILE: rtl/stepper_floor_positioner_unit.sv
// Results are registered in the output register, or in the skid on a stall. Throughput:
// one item per cycle while the skid is empty; the next state is formed in a single pass
// from the state registers and the accepted item, so ticks and requests may arrive back
// to back. A two-entry output stage keeps input ready high while one result waits to be
// taken. Reset (i_rst_n low, synchronous): cage at floor 1, direction up, phase 0,
// queue empty, steps_per_floor 4096, no output pending. No clearing pass is needed.
module stepper_floor_positioner_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: steps_per_floor, written when valid and ready are both high.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,     // steps_per_floor
    // Item input.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [3:0] target_floor, [7:4] zero
    input  logic        s_axis_tuser,   // [0] cmd: 0 floor request, 1 motor tick
    // Result output.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [7:0] coil_byte, [8] coil_write,
                                        // [12:9] current_floor, [13] going_up,
                                        // [14] moving, [15] arrived,
                                        // [18:16] pending_count,
                                        // [19] request_rejected, [23:20] zero
);
    import sfp_pkg::*;

    // The steps-per-floor register is always ready; the block's user must write it only
    // while no item is in flight, which the block itself does not enforce.
    logic [STEP_W-1:0] r_steps_per_floor;

    // Output stage: a main result register and a skid register behind it.
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;

    t_result result;
    logic    fire;
    logic    out_free;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_skid_valid;
    assign fire          = s_axis_tvalid && s_axis_tready;

    // The main register can load when it is empty or being drained this cycle.
    assign out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps_per_floor <= STEPS_RESET;
        end else if (i_cfg_valid) begin
            r_steps_per_floor <= i_cfg_data;
        end
    end

    // The core holds all positioning state and computes the result of the item
    // accepted in this cycle.
    sfp_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fire            (fire),
        .i_cmd             (s_axis_tuser),
        .i_target          (s_axis_tdata[FLOOR_W-1:0]),
        .i_steps_per_floor (r_steps_per_floor),
        .o_result          (result)
    );

    // Valid flags. When the skid holds a result, the input is stalled, so a
    // request is never accepted in the cycle the skid moves forward.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= fire;
            end
        end else if (fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (fire) begin
                r_out <= result;
            end
        end else if (fire) begin
            r_skid <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000,
                            r_out.request_rejected,
                            r_out.pending_count,
                            r_out.arrived,
                            r_out.moving,
                            r_out.going_up,
                            r_out.current_floor,
                            r_out.coil_write,
                            r_out.coil_byte};

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register filled while the output register is empty");

    a_skid_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid) && !$past(m_axis_tready))
        else $error("skid register loaded without an output stall");

    a_out_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or dropped while the receiver stalled");

endmodule

FILE: verif/tb_stepper_floor_positioner_unit.sv
`timescale 1ns / 100ps

module tb_stepper_floor_positioner_unit;

    import sfp_pkg::*;

    // One request on the slave side: the kind in tuser, the floor in tdata.
    typedef struct packed {
        logic               cmd;
        logic [FLOOR_W-1:0] target;
    } t_cage_request;

    // Half-step coil patterns before inversion, indexed by the phase counter.
    localparam logic [7:0] HALF_STEP_PATTERN [8] = '{
        8'h07, 8'h03, 8'h0b, 8'h09, 8'h0d, 8'h0c, 8'h0e, 8'h06
    };

    localparam int LONG_HOLD_CYCLES = 300;
    localparam int REPORT_LIMIT     = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    stepper_floor_positioner_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Requests waiting to be offered, and the reports the cage should give back.
    t_cage_request pending_cmds[$];
    t_result       expected_reports[$];

    int cmds_queued    = 0;
    int items_accepted = 0;
    int reports_seen   = 0;
    int mismatches     = 0;
    int arrivals       = 0;
    int rejections     = 0;

    // Flow controls set by the stimulus; the receiver reads both, the sender quiet_flow.
    bit quiet_flow        = 1'b0;
    bit hold_off_request  = 1'b0;

    // Shadow of the positioner: cage position, motor phase, and the floor queue.
    logic [STEP_W-1:0]  steps_per_floor;
    logic [FLOOR_W-1:0] cage_floor;
    logic               cage_up;
    logic [PHASE_W-1:0] coil_phase;
    logic [STEP_W-1:0]  steps_to_go;
    logic               cage_busy;
    logic [FLOOR_W-1:0] floor_requests [QUEUE_DEPTH];
    int                 queue_head;
    int                 cage_queued;

    // A zero step count behaves as a single step per floor.
    function automatic logic [STEP_W-1:0] floor_step_count();
        return (steps_per_floor == '0) ? 16'd1 : steps_per_floor;
    endfunction

    // Applies one accepted request to the shadow state and queues the report it causes.
    task automatic predict_positioner(input logic cmd, input logic [FLOOR_W-1:0] tgt);
        t_result            rpt;
        logic [FLOOR_W-1:0] head;
        logic               stepping;
        logic [7:0]         inverted;
        rpt = '0;
        stepping = 1'b0;
        if (cmd == CMD_REQUEST) begin
            if (tgt < FLOOR_LOW || tgt > FLOOR_TOP || cage_queued >= QUEUE_DEPTH) begin
                rpt.request_rejected = 1'b1;
                rejections++;
            end else begin
                floor_requests[(queue_head + cage_queued) % QUEUE_DEPTH] = tgt;
                cage_queued++;
            end
        end else if (cage_queued != 0) begin
            head = floor_requests[queue_head];
            if (!cage_busy) begin
                if (head == cage_floor) begin
                    // Already standing at the requested floor: served without moving.
                    queue_head = (queue_head + 1) % QUEUE_DEPTH;
                    cage_queued--;
                    rpt.arrived = 1'b1;
                end else begin
                    // The tick that starts a trip also drives its first half-step.
                    cage_up     = (head > cage_floor);
                    cage_busy   = 1'b1;
                    steps_to_go = floor_step_count();
                    stepping    = 1'b1;
                end
            end else if (steps_to_go != '0) begin
                stepping = 1'b1;
            end else begin
                // Floor boundary: hold the coils and move the cage by one floor.
                rpt.coil_byte  = COIL_HOLD;
                rpt.coil_write = 1'b1;
                if (cage_up) begin
                    if (cage_floor < FLOOR_HIGH) cage_floor = cage_floor + 1'b1;
                end else if (cage_floor > FLOOR_LOW) begin
                    cage_floor = cage_floor - 1'b1;
                end
                if (cage_floor == head) begin
                    cage_busy  = 1'b0;
                    queue_head = (queue_head + 1) % QUEUE_DEPTH;
                    cage_queued--;
                    rpt.arrived = 1'b1;
                end else begin
                    steps_to_go = floor_step_count();
                end
            end
            if (stepping) begin
                inverted       = ~HALF_STEP_PATTERN[coil_phase];
                rpt.coil_byte  = {inverted[4:0], 3'b000};
                rpt.coil_write = 1'b1;
                coil_phase     = cage_up ? coil_phase + 1'b1 : coil_phase - 1'b1;
                steps_to_go    = steps_to_go - 1'b1;
            end
        end
        if (rpt.arrived) arrivals++;
        rpt.current_floor = cage_floor;
        rpt.going_up      = cage_up;
        rpt.moving        = cage_busy;
        rpt.pending_count = PEND_W'(cage_queued);
        expected_reports.push_back(rpt);
    endtask

    // Sender: offers queued requests in bursts of random length, separated by random
    // gaps. A request that is offered stays on the bus until the block accepts it.
    int send_burst_left = 1;
    int send_gap_left   = 0;

    always @(posedge i_clk) begin : drive_requests
        logic          offer;
        t_cage_request next_cmd;
        offer = s_axis_tvalid;
        if (s_axis_tvalid && s_axis_tready) begin
            predict_positioner(s_axis_tuser, s_axis_tdata[FLOOR_W-1:0]);
            items_accepted++;
            offer = 1'b0;
        end
        if (!i_rst_n) begin
            offer = 1'b0;
        end else if (!offer) begin
            if (send_gap_left > 0 && !quiet_flow) begin
                send_gap_left--;
            end else if (pending_cmds.size() != 0) begin
                next_cmd = pending_cmds.pop_front();
                s_axis_tuser <= next_cmd.cmd;
                s_axis_tdata <= {4'b0000, next_cmd.target};
                offer = 1'b1;
                if (send_burst_left > 1) begin
                    send_burst_left--;
                end else begin
                    send_burst_left = $urandom_range(1, 24);
                    // Roughly one burst in four runs straight into the next one.
                    send_gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        s_axis_tvalid <= offer;
    end

    // Receiver: alternates ready and stalled runs on its own pattern. A long hold-off,
    // when asked for, keeps tready low long enough for the block to back up its input.
    int  long_hold_left = 0;
    int  ready_run_left = 0;
    bit  ready_level    = 1'b1;

    always @(posedge i_clk) begin : accept_reports
        logic take;
        if (hold_off_request) begin
            long_hold_left   = LONG_HOLD_CYCLES;
            hold_off_request = 1'b0;
        end
        if (long_hold_left > 0) begin
            long_hold_left--;
            take = 1'b0;
        end else if (quiet_flow) begin
            take = 1'b1;
        end else begin
            if (ready_run_left == 0) begin
                ready_level = ~ready_level;
                if (ready_level) begin
                    ready_run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                                 : $urandom_range(1, 12);
                end else begin
                    ready_run_left = $urandom_range(1, 8);
                end
            end
            ready_run_left--;
            take = ready_level;
        end
        m_axis_tready <= take;
    end

    // Checker: every report taken is compared with the oldest prediction.
    always @(posedge i_clk) begin : check_reports
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            reports_seen++;
            got.coil_byte        = m_axis_tdata[7:0];
            got.coil_write       = m_axis_tdata[8];
            got.current_floor    = m_axis_tdata[12:9];
            got.going_up         = m_axis_tdata[13];
            got.moving           = m_axis_tdata[14];
            got.arrived          = m_axis_tdata[15];
            got.pending_count    = m_axis_tdata[18:16];
            got.request_rejected = m_axis_tdata[19];
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] report %0d arrived with no prediction waiting: tdata %h",
                             $realtime, reports_seen, m_axis_tdata);
            end else begin
                want = expected_reports.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("[%0t] report %0d differs (expected / actual):",
                                 $realtime, reports_seen);
                        $display("    coil %h/%h write %b/%b floor %0d/%0d up %b/%b",
                                 want.coil_byte, got.coil_byte, want.coil_write,
                                 got.coil_write, want.current_floor, got.current_floor,
                                 want.going_up, got.going_up);
                        $display("    moving %b/%b arrived %b/%b pending %0d/%0d rejected %b/%b",
                                 want.moving, got.moving, want.arrived, got.arrived,
                                 want.pending_count, got.pending_count,
                                 want.request_rejected, got.request_rejected);
                    end
                end
            end
        end
    end

    task automatic queue_cmd(input logic cmd, input logic [FLOOR_W-1:0] tgt);
        t_cage_request req;
        req.cmd    = cmd;
        req.target = tgt;
        pending_cmds.push_back(req);
        cmds_queued++;
    endtask

    task automatic queue_tick();
        queue_cmd(CMD_TICK, FLOOR_W'($urandom_range(0, 15)));
    endtask

    // Mostly well-formed traffic: valid floors and plenty of ticks to carry the cage
    // there, with a share of out-of-range floors mixed in.
    task automatic queue_random_cmds(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 25) begin
                if ($urandom_range(0, 9) == 0)
                    queue_cmd(CMD_REQUEST, ($urandom_range(0, 1) == 0) ? 4'd0
                              : FLOOR_W'($urandom_range(NUM_FLOORS + 1, 15)));
                else
                    queue_cmd(CMD_REQUEST, FLOOR_W'($urandom_range(1, NUM_FLOORS)));
            end else begin
                queue_tick();
            end
        end
    endtask

    // Idle means every queued request was accepted and every report has come back.
    task automatic wait_until_idle();
        while (items_accepted != cmds_queued || expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_steps_per_floor(input logic [STEP_W-1:0] value);
        wait_until_idle();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        steps_per_floor = value;
    endtask

    initial begin : stimulus
        logic [FLOOR_W-1:0] next_floor;
        steps_per_floor = STEPS_RESET;
        cage_floor      = FLOOR_LOW;
        cage_up         = 1'b1;
        coil_phase      = '0;
        steps_to_go     = '0;
        cage_busy       = 1'b0;
        queue_head      = 0;
        cage_queued     = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset step count: out-of-range floors (zero, all ones,
        // just above the top), a tick on an empty queue, a full queue whose extra
        // request is dropped, and requests for the floor the cage already stands on.
        queue_cmd(CMD_REQUEST, 4'd0);
        queue_cmd(CMD_REQUEST, 4'd15);
        queue_cmd(CMD_REQUEST, FLOOR_W'(NUM_FLOORS + 1));
        queue_tick();
        repeat (QUEUE_DEPTH) queue_cmd(CMD_REQUEST, FLOOR_LOW);
        queue_cmd(CMD_REQUEST, FLOOR_TOP);
        repeat (QUEUE_DEPTH) queue_tick();

        // One half-step per floor: a short trip up and back down, each floor taking
        // one step and one boundary tick.
        set_steps_per_floor(16'd1);
        queue_cmd(CMD_REQUEST, 4'd4);
        repeat (6) queue_tick();
        queue_cmd(CMD_REQUEST, FLOOR_LOW);
        repeat (6) queue_tick();

        // Random traffic over several small step counts, zero among them.
        set_steps_per_floor(16'd2);
        queue_random_cmds(50);
        // Pause the sender until the cage has answered everything, then go on.
        wait_until_idle();
        queue_random_cmds(50);

        set_steps_per_floor(16'd3);
        hold_off_request = 1'b1;
        queue_random_cmds(100);

        set_steps_per_floor(16'd0);
        queue_random_cmds(100);

        set_steps_per_floor(16'd5);
        queue_random_cmds(100);

        set_steps_per_floor(16'd1);
        queue_random_cmds(80);
        // Enough ticks to serve whatever is still queued, so the cage ends up at rest.
        repeat (64) queue_tick();
        wait_until_idle();

        // Largest step count: the opening half-steps of a one-floor trip, with both
        // sides running flat out.
        set_steps_per_floor(16'hFFFF);
        next_floor = (cage_floor == FLOOR_TOP) ? cage_floor - 1'b1 : cage_floor + 1'b1;
        quiet_flow = 1'b1;
        queue_cmd(CMD_REQUEST, next_floor);
        repeat (32) queue_tick();
        wait_until_idle();
        quiet_flow = 1'b0;

        repeat (10) @(posedge i_clk);
        $display("Sent %0d requests and checked %0d reports: %0d arrivals, %0d dropped floors,",
                 items_accepted, reports_seen, arrivals, rejections);
        $display("step counts 4096, 1, 2, 3, 0, 5 and 65535, with a %0d-cycle output hold-off.",
                 LONG_HOLD_CYCLES);
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d reports never came", mismatches,
                     expected_reports.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #(10_000_000);
        $display("Timed out with %0d of %0d requests accepted", items_accepted, cmds_queued);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
